>>> hdl/hkr_pkg.sv
// package: shared types, constants and the usage code to character map
`timescale 1ns / 1ps
`default_nettype none

package hkr_pkg;

    // slots carried by one boot keyboard report
    localparam int INPUT_SLOTS    = 6;
    localparam int KEY_SLOTS_DEF  = 6;
    localparam int CODE_W         = 8;
    localparam int CHAR_W         = 7;

    localparam logic [7:0] MIN_REPORT_LEN = 8'd8;
    // left shift and right shift bits of the modifier byte
    localparam logic [7:0] SHIFT_MASK     = 8'h22;

    // usage codes
    localparam logic [7:0] CODE_NONE      = 8'd0;
    localparam logic [7:0] CODE_A         = 8'd4;
    localparam logic [7:0] CODE_Z         = 8'd29;
    localparam logic [7:0] CODE_1         = 8'd30;
    localparam logic [7:0] CODE_9         = 8'd38;
    localparam logic [7:0] CODE_0         = 8'd39;
    localparam logic [7:0] CODE_ENTER     = 8'd40;
    localparam logic [7:0] CODE_BACKSPACE = 8'd42;
    localparam logic [7:0] CODE_SPACE     = 8'd44;

    // one lane result: a character to emit, or none
    typedef struct packed {
        logic              hit;
        logic [CHAR_W-1:0] ch;
    } t_lane_res;

    // shifted digit row: ! @ # $ % ^ & * (
    function automatic logic [CHAR_W-1:0] shifted_digit(input logic [3:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            4'd0:    ch = 7'h21;
            4'd1:    ch = 7'h40;
            4'd2:    ch = 7'h23;
            4'd3:    ch = 7'h24;
            4'd4:    ch = 7'h25;
            4'd5:    ch = 7'h5E;
            4'd6:    ch = 7'h26;
            4'd7:    ch = 7'h2A;
            4'd8:    ch = 7'h28;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // map a usage code to a character; hit is low for unmapped codes
    function automatic t_lane_res map_code(input logic [CODE_W-1:0] code,
                                           input logic shift);
        t_lane_res res;
        logic [CHAR_W-1:0] off;
        res = '{hit: 1'b1, ch: '0};
        off = '0;
        case (code) inside
            [CODE_A:CODE_Z]: begin
                off    = code[CHAR_W-1:0] - CODE_A[CHAR_W-1:0];
                res.ch = (shift ? 7'h41 : 7'h61) + off;
            end
            [CODE_1:CODE_9]: begin
                off    = code[CHAR_W-1:0] - CODE_1[CHAR_W-1:0];
                res.ch = shift ? shifted_digit(off[3:0]) : 7'h31 + off;
            end
            CODE_0:         res.ch = shift ? 7'h29 : 7'h30;
            CODE_ENTER:     res.ch = 7'd10;
            CODE_BACKSPACE: res.ch = 7'd8;
            CODE_SPACE:     res.ch = 7'h20;
            default:        res.hit = 1'b0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/hkr_if.sv
// interfaces: report input channel and character output channel
`timescale 1ns / 1ps
`default_nettype none

interface hkr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
    logic [7:0] report_length;

    modport source (output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
                    key_slot_3, key_slot_4, key_slot_5, report_length, input ready);
    modport sink   (input valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
                    key_slot_3, key_slot_4, key_slot_5, report_length, output ready);
endinterface

interface hkr_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_of_run;

    modport source (output valid, char_code, last_of_run, input ready);
    modport sink   (input valid, char_code, last_of_run, output ready);
endinterface

`default_nettype wire

>>> hdl/hkr_lane.sv
// lane: checks one slot against the previous report and maps it to a character
`timescale 1ns / 1ps
`default_nettype none

module hkr_lane #(
    parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEF
) (
    input  wire logic [hkr_pkg::CODE_W-1:0] i_code,
    input  wire logic                       i_shift,
    input  wire logic [hkr_pkg::CODE_W-1:0] i_prev [KEY_SLOTS],
    output hkr_pkg::t_lane_res              o_res
);
    import hkr_pkg::*;

    logic      seen;
    t_lane_res mapped;

    always_comb begin
        seen = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (i_prev[j] == i_code) seen = 1'b1;
        end
    end

    assign mapped    = map_code(i_code, i_shift);
    assign o_res.hit = (i_code != CODE_NONE) && !seen && mapped.hit;
    assign o_res.ch  = mapped.ch;

endmodule

`default_nettype wire

>>> hdl/hkr_merge.sv
// merge: holds lane results and sends the characters out in slot order
`timescale 1ns / 1ps
`default_nettype none

module hkr_merge #(
    parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  hkr_pkg::t_lane_res i_res [KEY_SLOTS],
    output logic               o_ready,
    hkr_out_if.source          o_char
);
    import hkr_pkg::*;

    // hold stage: one decoded report waiting for the send stage
    logic                 r_a_valid, n_a_valid;
    logic [KEY_SLOTS-1:0] r_a_mask,  n_a_mask;
    logic [CHAR_W-1:0]    r_a_char [KEY_SLOTS];
    // send stage: characters still to go out
    logic [KEY_SLOTS-1:0] r_b_mask,  n_b_mask;
    logic [CHAR_W-1:0]    r_b_char [KEY_SLOTS];

    logic [KEY_SLOTS-1:0] lowest;
    logic [KEY_SLOTS-1:0] rest;
    logic [CHAR_W-1:0]    sel_char;
    logic                 out_fire, b_free, a_move;

    assign lowest   = r_b_mask & (~r_b_mask + 1'b1);
    assign rest     = r_b_mask & ~lowest;
    assign out_fire = o_char.valid && o_char.ready;
    assign b_free   = (r_b_mask == '0) || (out_fire && rest == '0);
    assign a_move   = r_a_valid && b_free;
    assign o_ready  = !r_a_valid || a_move;

    always_comb begin
        sel_char = '0;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            if (lowest[k]) sel_char = sel_char | r_b_char[k];
        end
    end

    assign o_char.valid       = (r_b_mask != '0);
    assign o_char.char_code   = sel_char;
    assign o_char.last_of_run = (rest == '0);

    always_comb begin
        n_a_valid = r_a_valid;
        n_a_mask  = r_a_mask;
        n_b_mask  = r_b_mask;
        if (a_move) begin
            n_b_mask  = r_a_mask;
            n_a_valid = 1'b0;
        end else if (out_fire) begin
            n_b_mask = rest;
        end
        if (i_load) begin
            n_a_valid = 1'b1;
            for (int k = 0; k < KEY_SLOTS; k++) n_a_mask[k] = i_res[k].hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_mask  <= '0;
            r_b_mask  <= '0;
        end else begin
            r_a_valid <= n_a_valid;
            r_a_mask  <= n_a_mask;
            r_b_mask  <= n_b_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            for (int k = 0; k < KEY_SLOTS; k++) r_b_char[k] <= r_a_char[k];
        end
        if (i_load) begin
            for (int k = 0; k < KEY_SLOTS; k++) r_a_char[k] <= i_res[k].ch;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hid_keyboard_report_to_ascii_unit.sv
// top level: boot keyboard report to ascii character decoder
`timescale 1ns / 1ps
`default_nettype none

// Decodes HID boot keyboard reports into ASCII characters. Each report item carries
// the modifier byte, six key slots and the report length; reports shorter than 8
// bytes are taken and dropped with no effect. Every slot has its own lane that
// compares the code against the previous report's codes and maps it (letters,
// digits, shifted digit symbols, enter as 10, backspace as 8, space); a key emits
// only on the report where it first shows up. The characters of one report leave
// in slot order, one per cycle while the output is ready, with last_of_run set on
// the final one; a report that yields nothing gives no output item. A report is
// taken in the cycle it is offered while the hold stage is empty or moves on to
// the send stage, and the next report's characters follow the last of a run with
// no gap when they wait in the hold stage. The limit is the single output port:
// one character per cycle. A hold stage between the lanes and the send stage lets
// one more report be taken while characters still wait on a stalled output. A
// report goes through the hold stage and then the send stage to the output.
module hid_keyboard_report_to_ascii_unit #(
    parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hkr_in_if.sink    i_report,
    hkr_out_if.source o_char
);
    import hkr_pkg::*;

    // codes of the last full report, zero at reset
    logic [CODE_W-1:0] r_prev [KEY_SLOTS];

    logic [CODE_W-1:0] in_slot  [INPUT_SLOTS];
    logic [CODE_W-1:0] cur_slot [KEY_SLOTS];
    t_lane_res         lane_res [KEY_SLOTS];
    logic              shift;
    logic              full_report;
    logic              in_fire;
    logic              merge_ready;

    assign in_slot[0] = i_report.key_slot_0;
    assign in_slot[1] = i_report.key_slot_1;
    assign in_slot[2] = i_report.key_slot_2;
    assign in_slot[3] = i_report.key_slot_3;
    assign in_slot[4] = i_report.key_slot_4;
    assign in_slot[5] = i_report.key_slot_5;

    assign shift       = (i_report.modifier_bits & SHIFT_MASK) != 8'h00;
    assign full_report = i_report.report_length >= MIN_REPORT_LEN;
    assign i_report.ready = merge_ready;
    assign in_fire     = i_report.valid && merge_ready;

    // one lane per slot; slots past the report's six read as empty
    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        if (g < INPUT_SLOTS) begin : g_real
            assign cur_slot[g] = in_slot[g];
        end else begin : g_empty
            assign cur_slot[g] = CODE_NONE;
        end

        hkr_lane #(
            .KEY_SLOTS (KEY_SLOTS)
        ) u_lane (
            .i_code  (cur_slot[g]),
            .i_shift (shift),
            .i_prev  (r_prev),
            .o_res   (lane_res[g])
        );
    end

    // unmapped new codes are stored too: store the raw slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_SLOTS; k++) r_prev[k] <= CODE_NONE;
        end else if (in_fire && full_report) begin
            for (int k = 0; k < KEY_SLOTS; k++) r_prev[k] <= cur_slot[k];
        end
    end

    hkr_merge #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_fire && full_report),
        .i_res   (lane_res),
        .o_ready (merge_ready),
        .o_char  (o_char)
    );

endmodule

`default_nettype wire

>>> hdl/hkr_checker.sv
// checker: port level properties of the decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module hkr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [6:0] i_char_code,
    input wire logic       i_last_of_run
);

    // nothing goes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output item right after reset");

    // a stalled output item holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_char_code)
            && $stable(i_last_of_run))
        else $error("stalled output item changed");

    // a run continues in the very next cycle until its last item
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_of_run |=> i_out_valid)
        else $error("gap inside a run of characters");

    // an offered report only backs up while output items are waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid)
        else $error("input stalled with nothing waiting at the output");

endmodule

bind hid_keyboard_report_to_ascii_unit hkr_checker u_hkr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_report.valid),
    .i_in_ready    (i_report.ready),
    .i_out_valid   (o_char.valid),
    .i_out_ready   (o_char.ready),
    .i_char_code   (o_char.char_code),
    .i_last_of_run (o_char.last_of_run)
);

`default_nettype wire
